// File: hw/rtl/bal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and codes for the bounded array list: command and status
// codes, the item formats of both channels, and the per-cell operation code.
// ----------------------------------------------------------------------------
package bal_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_PUSH_HEAD = 3'd1,
    CMD_POP_AT    = 3'd2,
    CMD_POP_TAIL  = 3'd3,
    CMD_POP_HEAD  = 3'd4,
    CMD_REMOVE    = 3'd5,
    CMD_FIND      = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // What a cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_TAKE_LEFT  = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] value;
    logic [3:0]  position;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [3:0]  found_index;
    logic        found;
    status_e     status;
    logic [4:0]  count;
  } rsp_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/bal_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bal_intf
// Valid/ready channels of the bounded array list: one for command items and
// one for result items.
// ----------------------------------------------------------------------------
interface bal_cmd_if;
  logic               valid;
  logic               ready;
  bal_pkg::cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bal_rsp_if;
  logic               valid;
  logic               ready;
  bal_pkg::rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bal_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bal_cell
// One slot of the list. It holds one word, loads a new word or a neighbor's
// word on command, and compares its word against the search key.
// ----------------------------------------------------------------------------
module bal_cell #(
  parameter int DataWidth = 32
) (
  input  wire logic                 clk_i,
  input  wire bal_pkg::cell_op_e    ctrl_i,
  input  wire logic                 in_use_i,
  input  wire logic [DataWidth-1:0] key_i,
  input  wire logic [DataWidth-1:0] left_i,
  input  wire logic [DataWidth-1:0] right_i,
  output logic      [DataWidth-1:0] entry_o,
  output logic                      hit_o
);

  logic [DataWidth-1:0] entry_q;
  logic [DataWidth-1:0] entry_d;

  always_comb begin
    unique case (ctrl_i)
      bal_pkg::CELL_HOLD:       entry_d = entry_q;
      bal_pkg::CELL_LOAD:       entry_d = key_i;
      bal_pkg::CELL_TAKE_LEFT:  entry_d = left_i;
      bal_pkg::CELL_TAKE_RIGHT: entry_d = right_i;
      default:                  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // Only slots below the count take part in a search.
  assign hit_o   = in_use_i && (entry_q == key_i);

endmodule
`default_nettype wire

// File: hw/rtl/bounded_array_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list
// Ordered list of words with a fixed capacity, built as a row of cells that
// shift and compare in parallel; one command item gives one result item.
// ----------------------------------------------------------------------------
// Usage:
// Command items arrive on cmd_i (cmd, value, position) and result items leave
// on rsp_o (data_out, found_index, found, status, count), both valid/ready.
// Every command finishes in the cycle it is accepted: all cells shift in the
// same clock edge and all cells compare against the key at once, so the
// result item is valid in the cycle after acceptance and, while results are
// taken, a new command item is accepted in every cycle, one item per cycle.
// The result sits in an output register. While it waits, cmd_i.ready stays
// high as long as rsp_o.ready is high, so a new item is taken in the same
// cycle the old result leaves. When the receiver stalls, cmd_i.ready drops
// and the list state is frozen until the result has been taken.
// The capacity register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle, the block does not enforce it.
// Reset empties the list, sets the capacity to 16 and drops the result valid
// flag; the stored words and the held result are not cleared.
// ----------------------------------------------------------------------------
module bounded_array_list #(
  parameter int MaxDepth  = 16,
  parameter int DataWidth = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bal_cmd_if.sink         cmd_i,
  bal_rsp_if.source       rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i
);

  // Count and index widths, and the widths used to line up values of
  // differing size before comparing or truncating them.
  localparam int CntW = $clog2(MaxDepth + 1);
  localparam int IdxW = $clog2(MaxDepth);
  localparam int CmpW = (CntW > 5) ? CntW : 5;
  localparam int DatW = (DataWidth > 32) ? DataWidth : 32;

  // Configuration register.
  logic [4:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 5'd16;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Handshake and output register.
  logic               rsp_valid_q;
  bal_pkg::rsp_item_t rsp_q;
  bal_pkg::rsp_item_t rsp_d;
  logic               accept;

  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Cell row.
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      cnt_d;
  logic [DataWidth-1:0] entry_w [MaxDepth];
  logic [DataWidth-1:0] left_w  [MaxDepth];
  logic [DataWidth-1:0] right_w [MaxDepth];
  bal_pkg::cell_op_e    ctrl_w  [MaxDepth];
  logic [MaxDepth-1:0]  in_use_w;
  logic [MaxDepth-1:0]  hit_w;
  logic [DataWidth-1:0] key_w;
  logic [DatW-1:0]      val_x;

  assign val_x = DatW'(cmd_i.data.value);
  assign key_w = val_x[DataWidth-1:0];

  for (genvar g = 0; g < MaxDepth; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_inner_left
      assign left_w[g] = entry_w[g-1];
    end
    if (g == MaxDepth - 1) begin : g_last
      assign right_w[g] = entry_w[g];
    end else begin : g_inner_right
      assign right_w[g] = entry_w[g+1];
    end

    assign in_use_w[g] = CntW'(g) < cnt_q;

    bal_cell #(
      .DataWidth (DataWidth)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_w[g]),
      .in_use_i (in_use_w[g]),
      .key_i    (key_w),
      .left_i   (left_w[g]),
      .right_i  (right_w[g]),
      .entry_o  (entry_w[g]),
      .hit_o    (hit_w[g])
    );
  end

  // First match: isolate the lowest hit bit, then encode it.
  logic [MaxDepth-1:0] first_oh;
  logic [IdxW-1:0]     first_idx;
  logic                hit_any;

  assign first_oh = hit_w & (~hit_w + MaxDepth'(1));
  assign hit_any  = |hit_w;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < MaxDepth; i++) begin
      if (first_oh[i]) begin
        first_idx = first_idx | IdxW'(i);
      end
    end
  end

  // Command decode.
  logic [CmpW-1:0]      cntx;
  logic [CmpW-1:0]      posx;
  logic [CmpW-1:0]      capx;
  logic [CmpW-1:0]      eff_cap;
  logic                 full;
  logic                 empty;
  logic                 push_ok;
  logic                 at_head;
  logic                 take_en;
  logic                 clr;
  logic [IdxW-1:0]      take_idx;
  logic [DataWidth-1:0] rd_data;
  logic [DatW-1:0]      data_x;
  logic [CmpW-1:0]      fidx_x;
  logic [CmpW-1:0]      cnt_dx;
  logic                 found;
  bal_pkg::status_e     status;

  assign cntx = CmpW'(cnt_q);
  assign posx = CmpW'(cmd_i.data.position);
  assign capx = CmpW'(cap_q);

  // A capacity of zero acts as one; one above the depth acts as the depth.
  always_comb begin
    eff_cap = capx;
    if (capx == '0) begin
      eff_cap = CmpW'(1);
    end
    if (capx > CmpW'(MaxDepth)) begin
      eff_cap = CmpW'(MaxDepth);
    end
  end

  assign full  = cntx >= eff_cap;
  assign empty = cnt_q == '0;

  always_comb begin
    push_ok  = 1'b0;
    at_head  = 1'b0;
    take_en  = 1'b0;
    clr      = 1'b0;
    take_idx = '0;
    found    = 1'b0;
    fidx_x   = '0;
    status   = bal_pkg::ST_OK;
    unique case (cmd_i.data.cmd) inside
      bal_pkg::CMD_PUSH_TAIL, bal_pkg::CMD_PUSH_HEAD: begin
        if (full) begin
          status = bal_pkg::ST_FULL;
        end else begin
          push_ok = 1'b1;
          at_head = cmd_i.data.cmd == bal_pkg::CMD_PUSH_HEAD;
        end
      end
      bal_pkg::CMD_POP_AT: begin
        // An empty list is reported ahead of a bad position.
        if (empty) begin
          status = bal_pkg::ST_EMPTY;
        end else if (posx >= cntx) begin
          status = bal_pkg::ST_RANGE;
        end else begin
          take_en  = 1'b1;
          take_idx = IdxW'(posx);
        end
      end
      bal_pkg::CMD_POP_TAIL: begin
        if (empty) begin
          status = bal_pkg::ST_EMPTY;
        end else begin
          take_en  = 1'b1;
          take_idx = IdxW'(cnt_q - CntW'(1));
        end
      end
      bal_pkg::CMD_POP_HEAD: begin
        if (empty) begin
          status = bal_pkg::ST_EMPTY;
        end else begin
          take_en = 1'b1;
        end
      end
      bal_pkg::CMD_REMOVE, bal_pkg::CMD_FIND: begin
        if (hit_any) begin
          found  = 1'b1;
          fidx_x = CmpW'(first_idx);
          if (cmd_i.data.cmd == bal_pkg::CMD_REMOVE) begin
            take_en  = 1'b1;
            take_idx = first_idx;
          end
        end else begin
          status = bal_pkg::ST_NOTFOUND;
        end
      end
      bal_pkg::CMD_CLEAR: begin
        clr = 1'b1;
      end
      default: begin
        status = bal_pkg::ST_OK;
      end
    endcase
  end

  // Only pops return a word; searches report the index without data.
  always_comb begin
    rd_data = entry_w[take_idx];
    if (take_en && (cmd_i.data.cmd != bal_pkg::CMD_REMOVE)) begin
      data_x = DatW'(rd_data);
    end else begin
      data_x = '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (push_ok) begin
        cnt_d = cnt_q + CntW'(1);
      end else if (take_en) begin
        cnt_d = cnt_q - CntW'(1);
      end else if (clr) begin
        cnt_d = '0;
      end
    end
  end

  assign cnt_dx = CmpW'(cnt_d);

  always_comb begin
    rsp_d.data_out    = data_x[31:0];
    rsp_d.found_index = fidx_x[3:0];
    rsp_d.found       = found;
    rsp_d.status      = status;
    rsp_d.count       = cnt_dx[4:0];
  end

  // Per-cell control. A push at the front moves every cell up by one; a removal
  // moves every cell at or above the removed slot, but the top cell, down by one.
  always_comb begin
    for (int i = 0; i < MaxDepth; i++) begin
      ctrl_w[i] = bal_pkg::CELL_HOLD;
      if (accept) begin
        if (push_ok && at_head) begin
          ctrl_w[i] = (i == 0) ? bal_pkg::CELL_LOAD : bal_pkg::CELL_TAKE_LEFT;
        end else if (push_ok && (CntW'(i) == cnt_q)) begin
          ctrl_w[i] = bal_pkg::CELL_LOAD;
        end else if (take_en && (IdxW'(i) >= take_idx) && (i < MaxDepth - 1)) begin
          ctrl_w[i] = bal_pkg::CELL_TAKE_RIGHT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

`ifndef SYNTH
  // The count never runs past the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxDepth))
    else $error("list count exceeds depth");

  // A result waiting on a stalled receiver blocks new commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !cmd_i.ready)
    else $error("command accepted while result is stalled");

  // Every accepted command leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted command produced no result");

  // A successful push grows the list by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && push_ok) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("push did not grow the list by one");
`endif

endmodule
`default_nettype wire

// File: verif/bounded_array_list_test.sv
// ----------------------------------------------------------------------------
// bounded_array_list_test
// Self-checking bench for the bounded array list. Command items come from a
// queue filled by the stimulus process and go through a valid/ready driver.
// A shadow copy of the list predicts each result item when its command is
// accepted. The monitor compares every result, field by field, with the
// oldest prediction. The capacity register is rewritten between phases.
// ----------------------------------------------------------------------------
module bounded_array_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  bal_cmd_if cmd_bus ();
  bal_rsp_if rsp_bus ();

  bounded_array_list dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Command items waiting for the driver, and results predicted but not yet
  // seen on the result channel, oldest first.
  bal_pkg::cmd_item_t pending_cmds[$];
  bal_pkg::rsp_item_t predicted_rsps[$];

  // Shadow copy of the list and of its capacity register.
  logic [31:0] shadow_words[Depth];
  int          shadow_count;
  logic [4:0]  shadow_cap;

  // Percent of cycles in which the sender or the receiver holds off.
  int send_idle_pct;
  int recv_idle_pct;

  // Set at a rising edge when a command item was taken, read by the driver
  // at the following falling edge.
  logic cmd_taken;

  int cmds_issued;
  int rsps_checked;
  int mismatches;
  int cap_writes;
  int status_seen[5];

  // Words that searches and removals draw from, so that they hit often.
  logic [31:0] word_pool[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // All inputs are known from time zero on.
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.data  = '0;
    rsp_bus.ready = 1'b0;
  end

  // Applies one command to the shadow list and returns the result item the
  // block should give for it. Errors leave the list as it was.
  function automatic bal_pkg::rsp_item_t apply_list_cmd(bal_pkg::cmd_item_t c);
    bal_pkg::rsp_item_t r;
    int                 lim;
    int                 take_idx;
    int                 hit;
    r        = '0;
    r.status = bal_pkg::ST_OK;
    take_idx = -1;
    hit      = -1;
    // A capacity of zero behaves as one, anything above the depth as full depth.
    lim = (shadow_cap == 5'd0) ? 1 : ((shadow_cap > Depth) ? Depth : int'(shadow_cap));
    case (c.cmd)
      bal_pkg::CMD_PUSH_TAIL, bal_pkg::CMD_PUSH_HEAD: begin
        if (shadow_count >= lim) begin
          r.status = bal_pkg::ST_FULL;
        end else if (c.cmd == bal_pkg::CMD_PUSH_TAIL) begin
          shadow_words[shadow_count] = c.value;
          shadow_count++;
        end else begin
          for (int k = shadow_count; k > 0; k--) shadow_words[k] = shadow_words[k - 1];
          shadow_words[0] = c.value;
          shadow_count++;
        end
      end
      bal_pkg::CMD_POP_AT: begin
        // An empty list is reported before the index is looked at.
        if (shadow_count == 0) r.status = bal_pkg::ST_EMPTY;
        else if (int'(c.position) >= shadow_count) r.status = bal_pkg::ST_RANGE;
        else take_idx = int'(c.position);
      end
      bal_pkg::CMD_POP_TAIL: begin
        if (shadow_count == 0) r.status = bal_pkg::ST_EMPTY;
        else take_idx = shadow_count - 1;
      end
      bal_pkg::CMD_POP_HEAD: begin
        if (shadow_count == 0) r.status = bal_pkg::ST_EMPTY;
        else take_idx = 0;
      end
      bal_pkg::CMD_REMOVE, bal_pkg::CMD_FIND: begin
        for (int k = 0; k < shadow_count; k++) begin
          if (hit < 0 && shadow_words[k] == c.value) hit = k;
        end
        if (hit < 0) begin
          r.status = bal_pkg::ST_NOTFOUND;
        end else begin
          r.found       = 1'b1;
          r.found_index = hit[3:0];
          if (c.cmd == bal_pkg::CMD_REMOVE) take_idx = hit;
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    if (take_idx >= 0) begin
      // Only pops hand the word back; a removal reports where it matched.
      if (c.cmd != bal_pkg::CMD_REMOVE) r.data_out = shadow_words[take_idx];
      for (int k = take_idx; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k + 1];
      shadow_count--;
    end
    r.count = shadow_count[4:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 200) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    end else if (mismatches == 201) begin
      $display("%0t: further mismatches are only counted", $time);
    end
  endtask

  // Command driver: a held item stays on the bus until it is taken; a new one
  // goes out unless the sender decides to idle this cycle.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!cmd_bus.valid || cmd_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_bus.data  <= pending_cmds[0];
          cmd_bus.valid <= 1'b1;
          pending_cmds.delete(0);
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    rsp_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: checks result items, predicts accepted commands and tracks the
  // capacity register.
  always @(posedge clk) begin
    bal_pkg::rsp_item_t want;
    bal_pkg::rsp_item_t got;
    if (!rst_n) begin
      cmd_taken    <= 1'b0;
      shadow_count = 0;
      shadow_cap   = 5'd16;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = rsp_bus.data;
        if (predicted_rsps.size() == 0) begin
          note_mismatch("unrequested result, count", '0, 32'(got.count));
        end else begin
          want = predicted_rsps[0];
          predicted_rsps.delete(0);
          rsps_checked++;
          if (int'(want.status) < 5) status_seen[int'(want.status)]++;
          if (got.data_out !== want.data_out)
            note_mismatch("data_out", want.data_out, got.data_out);
          if (got.found_index !== want.found_index)
            note_mismatch("found_index", 32'(want.found_index), 32'(got.found_index));
          if (got.found !== want.found)
            note_mismatch("found", 32'(want.found), 32'(got.found));
          if (got.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
          if (got.count !== want.count)
            note_mismatch("count", 32'(want.count), 32'(got.count));
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        predicted_rsps.insert(predicted_rsps.size(), apply_list_cmd(cmd_bus.data));
      end
      if (cfg_we) shadow_cap = cfg_wdata;
      cmd_taken <= cmd_bus.valid && cmd_bus.ready;
    end
  end

  task automatic queue_cmd(input bal_pkg::cmd_e c, input logic [31:0] v,
                           input logic [3:0] p);
    bal_pkg::cmd_item_t item;
    item.cmd      = c;
    item.value    = v;
    item.position = p;
    pending_cmds.insert(pending_cmds.size(), item);
    cmds_issued++;
  endtask

  task automatic wait_drained();
    while (rsps_checked != cmds_issued) @(negedge clk);
  endtask

  // The register is only written while nothing is in flight.
  task automatic set_capacity(input logic [4:0] v);
    wait_drained();
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_writes++;
  endtask

  // Random commands in runs that lean toward filling or draining the list,
  // so that both the full and the empty ends are reached often.
  task automatic run_random(input int n, input int send_pct, input int recv_pct);
    bit            grow;
    int            roll;
    bal_pkg::cmd_e c;
    logic [31:0]   v;
    logic [3:0]    p;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (word_pool[k]) word_pool[k] = $urandom;
    grow = 1'b1;
    @(posedge clk);
    for (int k = 0; k < n; k++) begin
      if (k % 24 == 0) grow = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (grow) begin
        c = (roll < 30) ? bal_pkg::CMD_PUSH_TAIL : (roll < 55) ? bal_pkg::CMD_PUSH_HEAD :
            (roll < 63) ? bal_pkg::CMD_POP_AT    : (roll < 68) ? bal_pkg::CMD_POP_TAIL  :
            (roll < 73) ? bal_pkg::CMD_POP_HEAD  : (roll < 82) ? bal_pkg::CMD_REMOVE    :
            (roll < 98) ? bal_pkg::CMD_FIND      : bal_pkg::CMD_CLEAR;
      end else begin
        c = (roll < 12) ? bal_pkg::CMD_PUSH_TAIL : (roll < 22) ? bal_pkg::CMD_PUSH_HEAD :
            (roll < 42) ? bal_pkg::CMD_POP_AT    : (roll < 55) ? bal_pkg::CMD_POP_TAIL  :
            (roll < 68) ? bal_pkg::CMD_POP_HEAD  : (roll < 81) ? bal_pkg::CMD_REMOVE    :
            (roll < 98) ? bal_pkg::CMD_FIND      : bal_pkg::CMD_CLEAR;
      end
      roll = $urandom_range(99);
      v = (roll < 60) ? word_pool[$urandom_range(7)] :
          (roll < 65) ? 32'h0 : (roll < 70) ? 32'hFFFF_FFFF : 32'($urandom);
      p = $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      queue_cmd(c, v, p);
    end
  endtask

  initial begin
    send_idle_pct = 17;
    recv_idle_pct = 80;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed part at the reset capacity: pops and searches on an empty
    // list, pushes at both ends with extreme words, index errors, a pop from
    // the middle, a removal, a miss and a clear.
    queue_cmd(bal_pkg::CMD_POP_HEAD, 32'h0, 4'd0);
    queue_cmd(bal_pkg::CMD_POP_TAIL, 32'h0, 4'd0);
    queue_cmd(bal_pkg::CMD_POP_AT, 32'h0, 4'd5);
    queue_cmd(bal_pkg::CMD_FIND, 32'h0, 4'd0);
    queue_cmd(bal_pkg::CMD_REMOVE, 32'h0, 4'd0);
    queue_cmd(bal_pkg::CMD_PUSH_TAIL, 32'hFFFF_FFFF, 4'd0);
    queue_cmd(bal_pkg::CMD_PUSH_TAIL, 32'h0, 4'd0);
    queue_cmd(bal_pkg::CMD_PUSH_HEAD, 32'hA5A5_A5A5, 4'd0);
    queue_cmd(bal_pkg::CMD_PUSH_HEAD, 32'h5A5A_5A5A, 4'd0);
    queue_cmd(bal_pkg::CMD_FIND, 32'h0, 4'd0);
    queue_cmd(bal_pkg::CMD_POP_AT, 32'h0, 4'd15);
    queue_cmd(bal_pkg::CMD_POP_AT, 32'h0, 4'd4);
    queue_cmd(bal_pkg::CMD_POP_AT, 32'h0, 4'd1);
    queue_cmd(bal_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 4'd0);
    queue_cmd(bal_pkg::CMD_FIND, 32'h1234_5678, 4'd0);
    queue_cmd(bal_pkg::CMD_CLEAR, 32'h0, 4'd0);

    // A capacity of zero must behave as one entry.
    set_capacity(5'd0);
    queue_cmd(bal_pkg::CMD_PUSH_TAIL, 32'h0000_0001, 4'd0);
    queue_cmd(bal_pkg::CMD_PUSH_HEAD, 32'h0000_0002, 4'd0);
    queue_cmd(bal_pkg::CMD_POP_AT, 32'h0, 4'd0);
    queue_cmd(bal_pkg::CMD_PUSH_HEAD, 32'hDEAD_BEEF, 4'd0);

    // The largest register value is clamped to the depth.
    set_capacity(5'd31);
    run_random(560, 17, 80);
    // Fill up, then drop the capacity below the count so pushes report full.
    for (int k = 0; k < 12; k++) queue_cmd(bal_pkg::CMD_PUSH_TAIL, 32'($urandom), 4'd0);
    set_capacity(5'd5);
    run_random(520, 80, 17);

    set_capacity(5'd16);
    run_random(260, 0, 0);
    set_capacity(5'd1);
    run_random(260, 0, 0);

    wait_drained();
    repeat (5) @(negedge clk);
    $display("Checked %0d result items over %0d capacity writes.", rsps_checked, cap_writes);
    $display("Statuses seen: %0d ok, %0d full, %0d empty, %0d bad index, %0d not found.",
             status_seen[bal_pkg::ST_OK], status_seen[bal_pkg::ST_FULL],
             status_seen[bal_pkg::ST_EMPTY], status_seen[bal_pkg::ST_RANGE],
             status_seen[bal_pkg::ST_NOTFOUND]);
    if (mismatches == 0 && predicted_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bal_pkg.sv
hw/rtl/bal_intf.sv
hw/rtl/bal_cell.sv
hw/rtl/bounded_array_list.sv
verif/bounded_array_list_test.sv
